// ===== hdl/psrl_pkg.sv =====
// Shared types and constants for the per-source SYN rate limiter.
`timescale 1ns / 1ps

package psrl_pkg;

  localparam int AddrW  = 32;
  localparam int HitsW  = 16;
  localparam int TicksW = 32;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_HIT_LIMIT     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_TICKS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BACKOFF_TICKS = 2'd2;

  localparam logic [HitsW-1:0]  HIT_LIMIT_RST     = 16'd10;
  localparam logic [TicksW-1:0] WINDOW_TICKS_RST  = 32'd1000;
  localparam logic [TicksW-1:0] BACKOFF_TICKS_RST = 32'd100;

  localparam logic [1:0] VERDICT_PASS       = 2'd0;
  localparam logic [1:0] VERDICT_OVER_LIMIT = 2'd1;
  localparam logic [1:0] VERDICT_BACKOFF    = 2'd2;
  localparam logic [1:0] VERDICT_FULL       = 2'd3;

  localparam logic MODE_SYN  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  addr;
    logic [HitsW-1:0]  hits;
    logic [TicksW-1:0] ticks;
  } entry_t;

  typedef struct packed {
    logic              shift_en;
    logic              match_en;
    logic              tick_en;
    logic              incr_en;
    logic [AddrW-1:0]  addr;
    logic [HitsW-1:0]  hit_limit;
    logic [TicksW-1:0] window;
  } ctl_t;

endpackage

// ===== hdl/psrl_cell.sv =====
// One table cell: holds a tracked source and hands it down the chain to fill holes.
`timescale 1ns / 1ps

module psrl_cell
  import psrl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctl_t   ctl_i,
  input  entry_t up_i,
  input  logic   down_valid_i,
  output entry_t ent_o,
  output logic   hit_o,
  output logic   over_o
);

  entry_t ent_q, ent_d;
  logic   match_q, over_q;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.tick_en) begin
      if (ent_q.valid) begin
        if (ent_q.ticks > TicksW'(1)) begin
          ent_d.ticks = ent_q.ticks - TicksW'(1);
        end else if (ent_q.hits == '0) begin
          ent_d.valid = 1'b0;
        end else begin
          ent_d.hits  = '0;
          ent_d.ticks = ctl_i.window;
        end
      end
    end else if (ctl_i.incr_en) begin
      if (match_q) begin
        ent_d.hits = ent_q.hits + HitsW'(1);
      end
    end else if (ctl_i.shift_en) begin
      if (!ent_q.valid && up_i.valid) begin
        ent_d = up_i;
      end else if (ent_q.valid && !down_valid_i) begin
        ent_d.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.valid <= 1'b0;
      match_q     <= 1'b0;
      over_q      <= 1'b0;
    end else begin
      ent_q <= ent_d;
      if (ctl_i.match_en) begin
        match_q <= ent_q.valid && (ent_q.addr == ctl_i.addr);
        over_q  <= ent_q.hits >= ctl_i.hit_limit;
      end
    end
  end

  assign ent_o  = ent_q;
  assign hit_o  = match_q;
  assign over_o = match_q & over_q;

endmodule

// ===== hdl/psrl_count_tree.sv =====
// Registered adder tree that counts the valid cells of the chain.
`timescale 1ns / 1ps

module psrl_count_tree #(
  parameter int ENTRIES = 256,
  localparam int CntW   = $clog2(ENTRIES + 1)
) (
  input  logic               clk_i,
  input  logic [ENTRIES-1:0] valid_i,
  output logic [CntW-1:0]    count_o
);

  localparam int Nodes = ENTRIES - 1;

  logic [CntW-1:0] node_q [Nodes];

  for (genvar n = 0; n < Nodes; n++) begin : g_node
    localparam int Lc = 2 * n + 1;
    localparam int Rc = 2 * n + 2;
    logic [CntW-1:0] lv, rv;

    if (Lc < Nodes) begin : g_l_node
      assign lv = node_q[Lc];
    end else begin : g_l_leaf
      assign lv = CntW'(valid_i[Lc-Nodes]);
    end

    if (Rc < Nodes) begin : g_r_node
      assign rv = node_q[Rc];
    end else begin : g_r_leaf
      assign rv = CntW'(valid_i[Rc-Nodes]);
    end

    always_ff @(posedge clk_i) begin
      node_q[n] <= lv + rv;
    end
  end

  assign count_o = node_q[0];

endmodule

// ===== hdl/per_source_syn_rate_limiter_unit.sv =====
// Top level of the per-source SYN rate limiter: control, config registers and cell chain.
`timescale 1ns / 1ps

// Takes one transaction at a time. A SYN that hits, or is dropped, goes through accept,
// match across all cells, decide and result register; with the throttle disabled it skips
// the decide step. A SYN that inserts also passes an insert step and waits there until the
// top cell of the chain is free; tracked sources move down one cell per cycle into holes
// while the unit is idle or inserting. A tick waits in a count step for the registered
// tree that recounts the valid cells. A transaction is accepted while a previous result
// waits to be taken. TABLE_ENTRIES ranges from 4 to 65536. No clearing pass is needed
// after reset.

module per_source_syn_rate_limiter_unit
  import psrl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  localparam int CntW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [AddrW-1:0]   source_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         verdict_o,
  output logic [CntW-1:0]    entries_in_use_o
);

  localparam int TreeLat = $clog2(TABLE_ENTRIES);
  localparam int WaitW   = $clog2(TreeLat + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DECIDE,
    ST_INSERT,
    ST_TICK,
    ST_COUNT,
    ST_RESP
  } state_e;

  state_e            state_q;
  logic [AddrW-1:0]  addr_q;
  logic [1:0]        verdict_q;
  logic [CntW-1:0]   count_q;
  logic [WaitW-1:0]  wait_q;
  logic [TicksW-1:0] backoff_q;
  logic              out_valid_q;
  logic [1:0]        out_verdict_q;
  logic [CntW-1:0]   out_count_q;

  logic [HitsW-1:0]  hit_limit_q;
  logic [TicksW-1:0] window_q;
  logic [TicksW-1:0] backoff_ticks_q;

  ctl_t              ctl;
  entry_t            ins_ent;
  entry_t            ent   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_v, hit_v, over_v;
  logic [CntW-1:0]   tree_count;
  logic              accept, hit_any, over_any, ins_take;

  assign accept   = in_valid_i & in_ready_o;
  assign hit_any  = |hit_v;
  assign over_any = |over_v;
  assign ins_take = (state_q == ST_INSERT) && !valid_v[TABLE_ENTRIES-1];

  always_comb begin
    ctl.shift_en  = (state_q == ST_IDLE) || (state_q == ST_INSERT);
    ctl.match_en  = (state_q == ST_MATCH);
    ctl.tick_en   = (state_q == ST_TICK);
    ctl.incr_en   = (state_q == ST_DECIDE) && hit_any && !over_any;
    ctl.addr      = addr_q;
    ctl.hit_limit = hit_limit_q;
    ctl.window    = window_q;

    ins_ent.valid = (state_q == ST_INSERT);
    ins_ent.addr  = addr_q;
    ins_ent.hits  = HitsW'(1);
    ins_ent.ticks = window_q;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t up;
    logic   down_valid;

    if (i == TABLE_ENTRIES - 1) begin : g_top
      assign up = ins_ent;
    end else begin : g_mid
      assign up = ent[i+1];
    end

    if (i == 0) begin : g_bottom
      assign down_valid = 1'b1;
    end else begin : g_rest
      assign down_valid = ent[i-1].valid;
    end

    psrl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .up_i        (up),
      .down_valid_i(down_valid),
      .ent_o       (ent[i]),
      .hit_o       (hit_v[i]),
      .over_o      (over_v[i])
    );

    assign valid_v[i] = ent[i].valid;
  end

  psrl_count_tree #(
    .ENTRIES(TABLE_ENTRIES)
  ) u_count (
    .clk_i  (clk_i),
    .valid_i(valid_v),
    .count_o(tree_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_limit_q     <= HIT_LIMIT_RST;
      window_q        <= WINDOW_TICKS_RST;
      backoff_ticks_q <= BACKOFF_TICKS_RST;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        CFG_HIT_LIMIT:     hit_limit_q     <= cfg_data_i[HitsW-1:0];
        CFG_WINDOW_TICKS:  window_q        <= cfg_data_i[TicksW-1:0];
        CFG_BACKOFF_TICKS: backoff_ticks_q <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      addr_q        <= '0;
      verdict_q     <= VERDICT_PASS;
      count_q       <= '0;
      wait_q        <= '0;
      backoff_q     <= '0;
      out_valid_q   <= 1'b0;
      out_verdict_q <= VERDICT_PASS;
      out_count_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            addr_q  <= source_address_i;
            state_q <= (mode_i == MODE_TICK) ? ST_TICK : ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (hit_limit_q == '0) begin
            verdict_q <= VERDICT_PASS;
            state_q   <= ST_RESP;
          end else begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (hit_any) begin
            verdict_q <= over_any ? VERDICT_OVER_LIMIT : VERDICT_PASS;
            state_q   <= ST_RESP;
          end else if (backoff_q != '0) begin
            verdict_q <= VERDICT_BACKOFF;
            state_q   <= ST_RESP;
          end else if (count_q == CntW'(TABLE_ENTRIES)) begin
            backoff_q <= backoff_ticks_q;
            verdict_q <= VERDICT_FULL;
            state_q   <= ST_RESP;
          end else begin
            state_q <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (ins_take) begin
            count_q   <= count_q + CntW'(1);
            verdict_q <= VERDICT_PASS;
            state_q   <= ST_RESP;
          end
        end
        ST_TICK: begin
          if (backoff_q != '0) begin
            backoff_q <= backoff_q - TicksW'(1);
          end
          verdict_q <= VERDICT_PASS;
          wait_q    <= '0;
          state_q   <= ST_COUNT;
        end
        ST_COUNT: begin
          if (wait_q == WaitW'(TreeLat)) begin
            count_q <= tree_count;
            state_q <= ST_RESP;
          end else begin
            wait_q <= wait_q + WaitW'(1);
          end
        end
        ST_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_verdict_q <= verdict_q;
            out_count_q   <= count_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign verdict_o        = out_verdict_q;
  assign entries_in_use_o = out_count_q;

endmodule

// ===== hdl/psrl_checker.sv =====
// Port-level checks for the rate limiter, bound to the top level.
`timescale 1ns / 1ps

module psrl_checker
  import psrl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  localparam int CntW = $clog2(TABLE_ENTRIES + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         verdict_o,
  input logic [CntW-1:0]    entries_in_use_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(verdict_o) && $stable(entries_in_use_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while one is in flight");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entries_in_use_o <= CntW'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_FULL) |->
      entries_in_use_o == CntW'(TABLE_ENTRIES))
    else $error("table-full drop with free entries");

  a_over_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_OVER_LIMIT) |-> entries_in_use_o != '0)
    else $error("over-limit drop with empty table");

endmodule

bind per_source_syn_rate_limiter_unit psrl_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_psrl_checker (.*);

// ===== tb/per_source_syn_rate_limiter_unit_tb.sv =====
// Self-checking testbench for the per-source SYN rate limiter: directed table, then random phases.
`timescale 1ns / 1ps

module per_source_syn_rate_limiter_unit_tb;
  import psrl_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int CycleLimit = 2000000;
  localparam int DirRows = 25;
  localparam int NumPhases = 6;
  localparam int PoolSize = 12;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [1:0]      verdict;
    logic [CntW-1:0] in_use;
  } syn_result_t;

  typedef struct {
    row_kind_e           kind;
    logic                mode;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [31:0]         value;
    bit                  typed;
    logic [1:0]          verdict;
    logic [CntW-1:0]     in_use;
  } dir_row_t;

  typedef struct {
    logic [HitsW-1:0]  limit;
    logic [TicksW-1:0] window;
    logic [TicksW-1:0] backoff;
    int                items;
    int                tick_pct;
    int                new_pct;
  } phase_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_wr_en_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               mode_i = MODE_SYN;
  logic [AddrW-1:0]   source_address_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         verdict_o;
  logic [CntW-1:0]    entries_in_use_o;

  per_source_syn_rate_limiter_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .source_address_i(source_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_o       (verdict_o),
    .entries_in_use_o(entries_in_use_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the throttle table and registers
  bit                ent_valid [TABLE_ENTRIES];
  logic [AddrW-1:0]  ent_addr  [TABLE_ENTRIES];
  logic [HitsW-1:0]  ent_hits  [TABLE_ENTRIES];
  logic [TicksW-1:0] ent_left  [TABLE_ENTRIES];
  logic [TicksW-1:0] backoff_left = '0;
  logic [HitsW-1:0]  limit_reg   = HIT_LIMIT_RST;
  logic [TicksW-1:0] window_reg  = WINDOW_TICKS_RST;
  logic [TicksW-1:0] backoff_reg = BACKOFF_TICKS_RST;

  syn_result_t pending_results [$];
  syn_result_t oldest;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;
  int          verdict_tally [4];
  int          peak_in_use = 0;
  int          txn_cnt = 0;
  bit          idle_on = 1'b1;

  dir_row_t    dir_tab [DirRows];
  phase_t      phases [NumPhases];
  logic [AddrW-1:0] pool [PoolSize];

  function automatic void throttle_decide(input logic m, input logic [AddrW-1:0] a,
                                          output logic [1:0] v,
                                          output logic [CntW-1:0] n);
    int  free_idx;
    int  cnt;
    bit  found;
    v = VERDICT_PASS;
    found = 1'b0;
    free_idx = -1;
    cnt = 0;
    if (m == MODE_TICK) begin
      if (backoff_left != 0) backoff_left--;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (ent_valid[i]) begin
          if (ent_left[i] > 1) begin
            ent_left[i]--;
          end else if (ent_hits[i] == 0) begin
            ent_valid[i] = 1'b0;
          end else begin
            ent_hits[i] = '0;
            ent_left[i] = window_reg;
          end
        end
      end
    end else if (limit_reg != 0) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!found && ent_valid[i] && ent_addr[i] == a) begin
          found = 1'b1;
          if (ent_hits[i] >= limit_reg) v = VERDICT_OVER_LIMIT;
          else ent_hits[i]++;
        end
      end
      if (!found) begin
        if (backoff_left != 0) begin
          v = VERDICT_BACKOFF;
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (free_idx < 0 && !ent_valid[i]) free_idx = i;
          if (free_idx < 0) begin
            backoff_left = backoff_reg;
            v = VERDICT_FULL;
          end else begin
            ent_valid[free_idx] = 1'b1;
            ent_addr[free_idx]  = a;
            ent_hits[free_idx]  = 16'd1;
            ent_left[free_idx]  = window_reg;
          end
        end
      end
    end
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (ent_valid[i]) cnt++;
    n = cnt[CntW-1:0];
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic drive_item(input logic m, input logic [AddrW-1:0] a, input bit typed,
                            input logic [1:0] tv, input logic [CntW-1:0] tn);
    logic [1:0]      pv;
    logic [CntW-1:0] pn;
    syn_result_t     r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= m;
    source_address_i <= a;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    throttle_decide(m, a, pv, pn);
    r.verdict = typed ? tv : pv;
    r.in_use  = typed ? tn : pn;
    pending_results.push_back(r);
    verdict_tally[pv]++;
    if (int'(pn) > peak_in_use) peak_in_use = int'(pn);
    txn_cnt++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] d);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    case (idx)
      CFG_HIT_LIMIT:     limit_reg = d[HitsW-1:0];
      CFG_WINDOW_TICKS:  window_reg = d;
      CFG_BACKOFF_TICKS: backoff_reg = d;
      default: ;
    endcase
    cfg_wr_en_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no transaction pending: verdict %0d, entries_in_use %0d",
                 verdict_o, entries_in_use_o);
          err_cnt++;
        end else begin
          oldest = pending_results.pop_front();
          if (verdict_o !== oldest.verdict) begin
            $error("verdict: expected %0d, actual %0d", oldest.verdict, verdict_o);
            err_cnt++;
          end
          if (entries_in_use_o !== oldest.in_use) begin
            $error("entries_in_use: expected %0d, actual %0d", oldest.in_use, entries_in_use_o);
            err_cnt++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 11);
      out_ready_i <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    dir_tab = '{
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h0000_0000, 1, VERDICT_PASS,       9'd1},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'hFFFF_FFFF, 1, VERDICT_PASS,       9'd2},
      '{ROW_ITEM, MODE_TICK, CFG_HIT_LIMIT,     32'hDEAD_BEEF, 1, VERDICT_PASS,       9'd2},
      '{ROW_CFG,  MODE_SYN,  CFG_HIT_LIMIT,     32'd2,         0, VERDICT_PASS,       9'd0},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h0000_0000, 1, VERDICT_PASS,       9'd2},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h0000_0000, 1, VERDICT_OVER_LIMIT, 9'd2},
      // lowered limit: both tracked sources now sit at or above it
      '{ROW_CFG,  MODE_SYN,  CFG_HIT_LIMIT,     32'd1,         0, VERDICT_PASS,       9'd0},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h0000_0000, 1, VERDICT_OVER_LIMIT, 9'd2},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'hFFFF_FFFF, 1, VERDICT_OVER_LIMIT, 9'd2},
      // throttle off: SYNs make no table updates
      '{ROW_CFG,  MODE_SYN,  CFG_HIT_LIMIT,     32'd0,         0, VERDICT_PASS,       9'd0},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h1234_5678, 1, VERDICT_PASS,       9'd2},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h0000_0000, 1, VERDICT_PASS,       9'd2},
      '{ROW_ITEM, MODE_TICK, CFG_HIT_LIMIT,     32'h0000_0000, 1, VERDICT_PASS,       9'd2},
      // zero-length window behaves like one tick
      '{ROW_CFG,  MODE_SYN,  CFG_HIT_LIMIT,     32'h0000_FFFF, 0, VERDICT_PASS,       9'd0},
      '{ROW_CFG,  MODE_SYN,  CFG_WINDOW_TICKS,  32'd0,         0, VERDICT_PASS,       9'd0},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'hA5A5_A5A5, 1, VERDICT_PASS,       9'd3},
      '{ROW_ITEM, MODE_TICK, CFG_HIT_LIMIT,     32'hFFFF_FFFF, 1, VERDICT_PASS,       9'd3},
      '{ROW_ITEM, MODE_TICK, CFG_HIT_LIMIT,     32'h0000_0000, 1, VERDICT_PASS,       9'd2},
      '{ROW_CFG,  MODE_SYN,  CFG_WINDOW_TICKS,  32'd1,         0, VERDICT_PASS,       9'd0},
      // unmapped index must not touch the limit
      '{ROW_CFG,  MODE_SYN,  CFG_UNUSED,        32'd1,         0, VERDICT_PASS,       9'd0},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h5A5A_5A5A, 1, VERDICT_PASS,       9'd3},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h5A5A_5A5A, 0, VERDICT_PASS,       9'd0},
      '{ROW_ITEM, MODE_TICK, CFG_HIT_LIMIT,     32'h5A5A_5A5A, 1, VERDICT_PASS,       9'd3},
      '{ROW_ITEM, MODE_TICK, CFG_HIT_LIMIT,     32'h0000_0000, 1, VERDICT_PASS,       9'd2},
      '{ROW_ITEM, MODE_SYN,  CFG_HIT_LIMIT,     32'h0000_0000, 0, VERDICT_PASS,       9'd0}
    };
    phases = '{
      '{16'd4,      32'd5,         32'hFFFF_FFFF, 250, 25, 0},
      '{16'd3,      32'd50,        32'd6,         420, 8,  80},
      '{16'd1,      32'd1,         32'd0,         200, 30, 20},
      '{16'd2,      32'd30,        32'd2,         350, 6,  85},
      '{16'd0,      32'hFFFF_FFFF, 32'd3,         150, 30, 50},
      '{16'hFFFF,   32'd8,         32'd2,         180, 20, 30}
    };
    foreach (verdict_tally[i]) verdict_tally[i] = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        drive_item(dir_tab[i].mode, dir_tab[i].value, dir_tab[i].typed,
                   dir_tab[i].verdict, dir_tab[i].in_use);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      if (p == NumPhases - 1) idle_on = 1'b0;
      cfg_write(CFG_HIT_LIMIT, CfgW'(phases[p].limit));
      cfg_write(CFG_WINDOW_TICKS, phases[p].window);
      cfg_write(CFG_BACKOFF_TICKS, phases[p].backoff);
      foreach (pool[k]) pool[k] = $urandom;
      repeat (phases[p].items) begin
        if ($urandom_range(0, 99) < phases[p].tick_pct)
          drive_item(MODE_TICK, $urandom, 1'b0, VERDICT_PASS, '0);
        else if ($urandom_range(0, 99) < phases[p].new_pct)
          drive_item(MODE_SYN, $urandom, 1'b0, VERDICT_PASS, '0);
        else
          drive_item(MODE_SYN, pool[$urandom_range(0, PoolSize - 1)], 1'b0, VERDICT_PASS, '0);
      end
    end

    wait_idle();
    repeat (TABLE_ENTRIES + 20) @(posedge clk_i);

    $display("%0d transactions over %0d cycles, peak table occupancy %0d of %0d",
             txn_cnt, cycle_cnt, peak_in_use, TABLE_ENTRIES);
    $display("verdicts: pass %0d, over limit %0d, backoff %0d, table full %0d",
             verdict_tally[VERDICT_PASS], verdict_tally[VERDICT_OVER_LIMIT],
             verdict_tally[VERDICT_BACKOFF], verdict_tally[VERDICT_FULL]);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
